// ----- hw/rtl/mwf_pkg.sv -----
package mwf_pkg;

	// Command codes carried by an input item.
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_STEP  = 2'd2;

	// Headings, clockwise from east.
	localparam logic [1:0] DIR_E = 2'd0;
	localparam logic [1:0] DIR_S = 2'd1;
	localparam logic [1:0] DIR_W = 2'd2;
	localparam logic [1:0] DIR_N = 2'd3;

	// Register word index and reset value of the exit column.
	localparam logic       REG_EXIT_COLUMN = 1'b0;
	localparam logic [3:0] EXIT_COL_RST    = 4'd11;

	// Access controls for one map memory.
	typedef struct packed {
		logic wr_en;
		logic wr_data;
		logic rd_en;
	} ram_ctl_t;

endpackage

// ----- hw/rtl/mwf_map_ram.sv -----
module mwf_map_ram #(
	parameter int DEPTH = 144,
	parameter int AW = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mwf_pkg::ram_ctl_t   ctl,
	input  logic [AW-1:0]       wr_addr,
	input  logic [AW-1:0]       rd_addr,
	output logic                rd_data
);

	logic             mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic             rd_data_q;

	// Storage array; no reset, the valid bits cover the cleared state.
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= ctl.wr_data;
		end
	end

	// Per-entry valid bits, cleared at once by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ctl.wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	// Registered read; an entry never written reads as zero. Data holds between reads.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_data_q <= 1'b0;
		end else if (ctl.rd_en) begin
			rd_data_q <= vld_q[rd_addr] & mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hw/rtl/maze_wall_follower_unit.sv -----
// Channel  | Direction | Handshake          | Payload
// input    | in        | in_valid/in_stall  | command, row, col, is_wall
// output   | out       | out_valid/out_stall| pos_row, pos_col, direction, first_visit,
//          |           |                    | reached_exit
// config   | in/out    | APB psel/penable   | exit_column at word 0
//
// A write item is done in the idle state. A start item goes straight to the visited read.
// A step item first scans and moves, unless the walker already stands in the exit column:
// the four neighbour wall bits are read one per cycle from the single read port of the
// wall memory, then the visited memory is read and updated.
// Reset clears both maps at once through per-cell valid bits; no clearing pass is needed.
// A stalled result waits in the output register while the next item is accepted; the block
// then holds in its last step until the register is free.
module maze_wall_follower_unit #(
	parameter int MAZE_SIDE = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [3:0]  row,
	input  logic [3:0]  col,
	input  logic        is_wall,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  pos_row,
	output logic [3:0]  pos_col,
	output logic [1:0]  direction,
	output logic        first_visit,
	output logic        reached_exit,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int         CELLS    = MAZE_SIDE * MAZE_SIDE;
	localparam int         AW       = $clog2(CELLS);
	localparam logic [3:0] LAST_IDX = 4'(MAZE_SIDE - 1);
	localparam logic [4:0] SIDE     = 5'(MAZE_SIDE);

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_MOVE, S_VIS, S_VWAIT} state_t;

	state_t      state_q;
	logic [3:0]  row_q, col_q;
	logic [1:0]  head_q;
	logic [2:0]  scan_q;
	logic [3:0]  blk_q;
	logic [3:0]  exit_q;
	logic        rd_vld_s1, rd_out_s1;
	logic [1:0]  rd_dir_s1;
	logic        out_valid_q, first_q, reached_q;
	logic [3:0]  pos_row_q, pos_col_q;
	logic [1:0]  dir_q;

	logic        in_acc, in_range, slot_free, cfg_wr;
	logic [1:0]  scan_dir;
	logic [3:0]  nb_row, nb_col;
	logic        nb_out;
	logic [1:0]  mv_dir;
	logic        mv_go;
	logic [3:0]  mv_row, mv_col;
	logic        wall_rd, vis_rd;
	mwf_pkg::ram_ctl_t wall_ctl, vis_ctl;
	logic [AW-1:0] wall_wr_addr, wall_rd_addr, cur_addr;

	function automatic logic [AW-1:0] cell_addr(input logic [3:0] r, input logic [3:0] c);
		logic [8:0] lin;
		lin = (9'(r) * 9'(MAZE_SIDE)) + 9'(c);
		return AW'(lin);
	endfunction

	// Input handshake: one item at a time.
	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign in_range  = ({1'b0, row} < SIDE) && ({1'b0, col} < SIDE);
	assign slot_free = !out_valid_q || !out_stall;

	// Neighbour of the walker in the heading being scanned, with the grid-edge check.
	assign scan_dir = scan_q[1:0];
	always_comb begin
		nb_row = row_q;
		nb_col = col_q;
		nb_out = 1'b0;
		unique case (scan_dir)
			mwf_pkg::DIR_E: begin
				nb_col = col_q + 4'd1;
				nb_out = (col_q == LAST_IDX);
			end
			mwf_pkg::DIR_S: begin
				nb_row = row_q + 4'd1;
				nb_out = (row_q == LAST_IDX);
			end
			mwf_pkg::DIR_W: begin
				nb_col = col_q - 4'd1;
				nb_out = (col_q == 4'd0);
			end
			mwf_pkg::DIR_N: begin
				nb_row = row_q - 4'd1;
				nb_out = (row_q == 4'd0);
			end
			default: begin
				nb_out = 1'b1;
			end
		endcase
	end

	// Right-hand rule over the four captured blocked bits.
	always_comb begin
		logic [1:0] rt, lf, bk;
		rt = head_q + 2'd1;
		lf = head_q + 2'd3;
		bk = head_q + 2'd2;
		mv_dir = bk;
		mv_go  = 1'b0;
		priority if (!blk_q[head_q] && blk_q[rt]) begin
			mv_dir = head_q;
			mv_go  = 1'b1;
		end else if (!blk_q[rt]) begin
			mv_dir = rt;
			mv_go  = 1'b1;
		end else if (!blk_q[lf]) begin
			mv_dir = lf;
			mv_go  = 1'b1;
		end else if (!blk_q[bk]) begin
			mv_go  = 1'b1;
		end else begin
			// Walled in on every side: only the heading reverses.
			mv_go  = 1'b0;
		end
	end

	// Position after a move; the cell ahead is known to lie inside the grid.
	always_comb begin
		mv_row = row_q;
		mv_col = col_q;
		unique case (mv_dir)
			mwf_pkg::DIR_E: mv_col = col_q + 4'd1;
			mwf_pkg::DIR_S: mv_row = row_q + 4'd1;
			mwf_pkg::DIR_W: mv_col = col_q - 4'd1;
			mwf_pkg::DIR_N: mv_row = row_q - 4'd1;
			default: mv_col = col_q;
		endcase
	end

	// Wall memory: written by write items, read one neighbour per scan cycle.
	assign wall_ctl.wr_en   = in_acc && (command == mwf_pkg::CMD_WRITE) && in_range;
	assign wall_ctl.wr_data = is_wall;
	assign wall_ctl.rd_en   = (state_q == S_SCAN) && !scan_q[2] && !nb_out;
	assign wall_wr_addr     = cell_addr(row, col);
	assign wall_rd_addr     = cell_addr(nb_row, nb_col);

	mwf_map_ram #(.DEPTH(CELLS), .AW(AW)) u_wall (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (wall_ctl),
		.wr_addr (wall_wr_addr),
		.rd_addr (wall_rd_addr),
		.rd_data (wall_rd)
	);

	// Visited memory: read the current cell, then mark it when the item is emitted.
	assign cur_addr        = cell_addr(row_q, col_q);
	assign vis_ctl.rd_en   = (state_q == S_VIS);
	assign vis_ctl.wr_en   = (state_q == S_VWAIT) && slot_free;
	assign vis_ctl.wr_data = 1'b1;

	mwf_map_ram #(.DEPTH(CELLS), .AW(AW)) u_visited (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (vis_ctl),
		.wr_addr (cur_addr),
		.rd_addr (cur_addr),
		.rd_data (vis_rd)
	);

	// Sequencer, walker state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			row_q       <= 4'd0;
			col_q       <= 4'd0;
			head_q      <= mwf_pkg::DIR_E;
			scan_q      <= 3'd0;
			blk_q       <= 4'd0;
			rd_vld_s1   <= 1'b0;
			rd_out_s1   <= 1'b0;
			rd_dir_s1   <= mwf_pkg::DIR_E;
			out_valid_q <= 1'b0;
			pos_row_q   <= 4'd0;
			pos_col_q   <= 4'd0;
			dir_q       <= mwf_pkg::DIR_E;
			first_q     <= 1'b0;
			reached_q   <= 1'b0;
		end else begin
			// The output register fills at the end of the emit step and empties when taken.
			if ((state_q == S_VWAIT) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			// Scan read pipeline: capture each blocked bit in the cycle after its read.
			rd_vld_s1 <= (state_q == S_SCAN) && !scan_q[2];
			rd_dir_s1 <= scan_dir;
			rd_out_s1 <= nb_out;
			if (rd_vld_s1) begin
				blk_q[rd_dir_s1] <= rd_out_s1 | wall_rd;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						unique case (command)
							mwf_pkg::CMD_START: begin
								if (in_range) begin
									row_q   <= row;
									col_q   <= col;
									head_q  <= mwf_pkg::DIR_E;
									state_q <= S_VIS;
								end
							end
							mwf_pkg::CMD_STEP: begin
								if (col_q == exit_q) begin
									state_q <= S_VIS;
								end else begin
									scan_q  <= 3'd0;
									state_q <= S_SCAN;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (scan_q[2]) begin
						state_q <= S_MOVE;
					end else begin
						scan_q <= scan_q + 3'd1;
					end
				end
				S_MOVE: begin
					head_q <= mv_dir;
					if (mv_go) begin
						row_q <= mv_row;
						col_q <= mv_col;
					end
					state_q <= S_VIS;
				end
				S_VIS: begin
					state_q <= S_VWAIT;
				end
				S_VWAIT: begin
					if (slot_free) begin
						pos_row_q   <= row_q;
						pos_col_q   <= col_q;
						dir_q       <= head_q;
						first_q     <= !vis_rd;
						reached_q   <= (col_q == exit_q);
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign pos_row      = pos_row_q;
	assign pos_col      = pos_col_q;
	assign direction    = dir_q;
	assign first_visit  = first_q;
	assign reached_exit = reached_q;

	// Configuration register.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exit_q <= mwf_pkg::EXIT_COL_RST;
		end else if (cfg_wr && (paddr[2] == mwf_pkg::REG_EXIT_COLUMN)) begin
			exit_q <= pwdata[3:0];
		end
	end

	assign prdata = (paddr[2] == mwf_pkg::REG_EXIT_COLUMN) ? {28'd0, exit_q} : 32'd0;

`ifndef ASSERT_OFF
	// The walker never leaves the grid.
	a_pos_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, row_q} < SIDE) && ({1'b0, col_q} < SIDE))
		else $error("walker position outside the grid");

	// A new result is loaded only at the end of the emit step.
	a_out_from_vwait: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_VWAIT))
		else $error("result loaded outside the emit step");

	// The scan counter stops at four reads.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (scan_q <= 3'd4))
		else $error("scan counter overran");

	// After the move decision the visited read always follows.
	a_move_then_vis: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOVE) |=> (state_q == S_VIS))
		else $error("move not followed by visited read");

	// A move changes the position by at most one cell in one axis.
	a_single_cell: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOVE) |=> (($past(row_q) == row_q) || ($past(col_q) == col_q)))
		else $error("walker moved diagonally");
`endif

endmodule
